// File: rtl/core/bca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_pkg
// Shared widths, register codes and stage counts for the brightness and
// contrast point operation.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int BRIGHT_W   = 9;
  localparam int CONTRAST_W = 8;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // Quotient bits resolved one per divider stage, below the saturation test.
  localparam int DIV_STAGES = 8;
  // Signed numerator, unsigned normalised denominator, divider remainder.
  localparam int NUM_W      = 27;
  localparam int DEN_W      = 15;
  localparam int REM_W      = DEN_W + DIV_STAGES;

  typedef enum logic {
    REG_BRIGHTNESS = 1'b0,
    REG_CONTRAST   = 1'b1
  } bca_reg_t;

endpackage

// File: rtl/core/bca_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_in_if / bca_out_if
// Valid/ready channels carrying one channel sample per request.
// ----------------------------------------------------------------------------
interface bca_in_if;
  import bca_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface bca_out_if;
  import bca_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

// File: rtl/core/brightness_contrast_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brightness_contrast_adjust
// A request passes stages 0 to 3, the divider, then the output buffer.
// Throughput: one sample per cycle; the pipeline moves as one, held only when
//   the two-entry output buffer is full.
// Reset (rst, synchronous): brightness and contrast clear to zero, all stage
//   valid bits and the output buffer empty. Data registers are not reset.
// ----------------------------------------------------------------------------
module brightness_contrast_adjust (
  input  logic                        clk,
  input  logic                        rst,
  bca_in_if.sink                      in_chan,
  bca_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bca_pkg::ADDR_W-1:0]  paddr,
  input  logic [bca_pkg::DATA_W-1:0]  pwdata,
  output logic [bca_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bca_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Registers are decoded on address bit 2 alone;
  // the low byte-lane bits are ignored.
  // --------------------------------------------------------------------------
  logic signed [BRIGHT_W-1:0]   brightness;
  logic signed [CONTRAST_W-1:0] contrast;
  bca_reg_t                     reg_sel;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = bca_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= '0;
      contrast   <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_BRIGHTNESS: brightness <= signed'(pwdata[BRIGHT_W-1:0]);
        REG_CONTRAST:   contrast   <= signed'(pwdata[CONTRAST_W-1:0]);
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BRIGHTNESS: prdata = DATA_W'(brightness);
      REG_CONTRAST:   prdata = DATA_W'(contrast);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control. Every stage advances together whenever the output buffer
  // has room; a full buffer holds the whole pipeline in place, so nothing is
  // dropped or repeated. Input is taken on the same condition.
  // --------------------------------------------------------------------------
  logic [1:0] ob_count;
  logic       adv;
  logic       push;
  logic       pop;

  assign adv           = (ob_count != 2'd2);
  assign in_chan.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 0: capture the sample.
  // --------------------------------------------------------------------------
  logic                s0_v;
  logic [SAMPLE_W-1:0] s0_x;

  // --------------------------------------------------------------------------
  // Stage 1: linear terms and the denominator.
  //   positive contrast: t = 100x + 100b - 127c, d = 25500 - 254c
  //   otherwise:         g = 25600 - 256m, s = x + b, m = -c, d = 25500
  // Config is read here, after the sample is registered in stage 0, so a write
  // made alongside the request is already visible.
  // --------------------------------------------------------------------------
  logic                s1_v;
  logic                s1_pos;
  logic signed [17:0]  s1_t;
  logic signed [16:0]  s1_g;
  logic signed [9:0]   s1_s;
  logic [7:0]          s1_m;
  logic signed [15:0]  s1_d;

  logic                pos_c;
  logic signed [17:0]  xs_c;
  logic signed [17:0]  bs_c;
  logic signed [17:0]  cs_c;
  logic signed [17:0]  t_c;
  logic [7:0]          m_c;
  logic signed [16:0]  g_c;
  logic signed [9:0]   s_c;
  logic signed [15:0]  d_c;

  always_comb begin
    pos_c = !contrast[CONTRAST_W-1] && (contrast != '0);
    xs_c  = signed'(18'(s0_x));
    bs_c  = 18'(brightness);
    cs_c  = 18'(contrast);
    t_c   = 18'sd100 * xs_c + 18'sd100 * bs_c - 18'sd127 * cs_c;
    m_c   = 8'(~contrast + 8'sd1);
    g_c   = 17'sd25600 - signed'({1'b0, m_c, 8'b0});
    s_c   = signed'({2'b0, s0_x}) + 10'(brightness);
    d_c   = pos_c ? (16'sd25500 - 16'sd254 * 16'(contrast)) : 16'sd25500;
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale to the full numerator.
  //   positive contrast: n = 255 t
  //   otherwise:         n = g s + 32640 m
  // --------------------------------------------------------------------------
  logic                    s2_v;
  logic signed [NUM_W-1:0] s2_n;
  logic signed [15:0]      s2_d;

  logic signed [NUM_W-1:0] n_pos_c;
  logic signed [NUM_W-1:0] n_neg_c;
  logic [NUM_W-1:0]        off_c;

  always_comb begin
    n_pos_c = 27'sd255 * NUM_W'(s1_t);
    off_c   = NUM_W'(s1_m) * 27'd32640;
    n_neg_c = NUM_W'(s1_g) * NUM_W'(s1_s) + signed'(off_c);
  end

  // --------------------------------------------------------------------------
  // Stage 3: make the denominator positive, flipping the numerator with it.
  // --------------------------------------------------------------------------
  logic                    s3_v;
  logic signed [NUM_W-1:0] s3_n;
  logic [DEN_W-1:0]        s3_d;

  // --------------------------------------------------------------------------
  // Stage 4 and the divider. Index 0 holds the sign and saturation flags and
  // the starting remainder; each later index settles one quotient bit, MSB
  // first, by a trial subtract of the shifted denominator.
  // A negative numerator rounds to zero or below and clamps to 0; a quotient
  // of 256 or more clamps to 255.
  // --------------------------------------------------------------------------
  logic                neg4_c;
  logic                sat4_c;
  logic [NUM_W-1:0]    lim4_c;

  always_comb begin
    neg4_c = s3_n[NUM_W-1];
    lim4_c = NUM_W'({s3_d, 8'b0});
    sat4_c = !neg4_c && (unsigned'(s3_n) >= lim4_c);
  end

  logic                dv_v   [0:DIV_STAGES];
  logic                dv_neg [0:DIV_STAGES];
  logic                dv_sat [0:DIV_STAGES];
  logic [DEN_W-1:0]    dv_d   [0:DIV_STAGES];
  logic [REM_W-1:0]    dv_rem [0:DIV_STAGES];
  logic [7:0]          dv_q   [0:DIV_STAGES];

  logic [REM_W-1:0]    dv_rem_next [1:DIV_STAGES];
  logic                dv_bit      [1:DIV_STAGES];

  always_comb begin
    for (int j = 1; j <= DIV_STAGES; j++) begin
      logic [REM_W:0] dsh;
      dsh            = (REM_W+1)'(dv_d[j-1]) << (DIV_STAGES - j);
      dv_bit[j]      = ((REM_W+1)'(dv_rem[j-1]) >= dsh);
      dv_rem_next[j] = dv_bit[j] ? REM_W'((REM_W+1)'(dv_rem[j-1]) - dsh) : dv_rem[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // Round to nearest, ties to even, then clamp. The remainder is below the
  // denominator, so its low DEN_W bits carry it whole.
  // --------------------------------------------------------------------------
  logic [DEN_W:0]      two_r_c;
  logic                up_c;
  logic [7:0]          q_c;
  logic [SAMPLE_W-1:0] res_c;

  always_comb begin
    q_c     = dv_q[DIV_STAGES];
    two_r_c = {dv_rem[DIV_STAGES][DEN_W-1:0], 1'b0};
    up_c    = (two_r_c > {1'b0, dv_d[DIV_STAGES]})
           || ((two_r_c == {1'b0, dv_d[DIV_STAGES]}) && q_c[0]);
    if (dv_neg[DIV_STAGES]) begin
      res_c = '0;
    end else if (dv_sat[DIV_STAGES]) begin
      res_c = '1;
    end else if (up_c && (q_c != 8'hFF)) begin
      res_c = q_c + 8'd1;
    end else begin
      res_c = q_c;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline data registers: advance on adv, otherwise hold.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x   <= in_chan.in_sample;

      s1_pos <= pos_c;
      s1_t   <= t_c;
      s1_g   <= g_c;
      s1_s   <= s_c;
      s1_m   <= m_c;
      s1_d   <= d_c;

      s2_n   <= s1_pos ? n_pos_c : n_neg_c;
      s2_d   <= s1_d;

      if (s2_d[15]) begin
        s3_n <= -s2_n;
        s3_d <= DEN_W'(-s2_d);
      end else begin
        s3_n <= s2_n;
        s3_d <= DEN_W'(s2_d);
      end

      dv_neg[0] <= neg4_c;
      dv_sat[0] <= sat4_c;
      dv_d[0]   <= s3_d;
      dv_rem[0] <= s3_n[REM_W-1:0];
      dv_q[0]   <= '0;

      for (int j = 1; j <= DIV_STAGES; j++) begin
        dv_neg[j] <= dv_neg[j-1];
        dv_sat[j] <= dv_sat[j-1];
        dv_d[j]   <= dv_d[j-1];
        dv_rem[j] <= dv_rem_next[j];
        dv_q[j]   <= {dv_q[j-1][6:0], dv_bit[j]};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      for (int j = 0; j <= DIV_STAGES; j++) begin
        dv_v[j] <= 1'b0;
      end
    end else if (adv) begin
      s0_v    <= in_chan.valid;
      s1_v    <= s0_v;
      s2_v    <= s1_v;
      s3_v    <= s2_v;
      dv_v[0] <= s3_v;
      for (int j = 1; j <= DIV_STAGES; j++) begin
        dv_v[j] <= dv_v[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer: head register drives out_chan, a second entry takes the
  // result that arrives while the head is stalled.
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ob_head;
  logic [SAMPLE_W-1:0] ob_tail;

  assign push = adv && dv_v[DIV_STAGES];
  assign pop  = (ob_count != 2'd0) && out_chan.ready;

  assign out_chan.valid      = (ob_count != 2'd0);
  assign out_chan.out_sample = ob_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_count <= 2'd0;
    end else begin
      ob_count <= ob_count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      ob_head <= res_c;
    end else if (push) begin
      if (ob_count == 2'd0) begin
        ob_head <= res_c;
      end else begin
        ob_tail <= res_c;
      end
    end else if (pop) begin
      ob_head <= ob_tail;
    end
  end

endmodule

// File: rtl/core/bca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_checker
// Port-level checks on the output channel and the output buffer behaviour.
// ----------------------------------------------------------------------------
module bca_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bca_pkg::SAMPLE_W-1:0] out_sample
);
  import bca_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_sample))
    else $error("stalled result changed");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // Input is refused only when finished results are waiting.
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input refused with no result pending");

endmodule

bind brightness_contrast_adjust bca_checker u_bca_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_sample (out_chan.out_sample)
);
